// ===== rtl/core/kwtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwtc_pkg
// Shared types, scanner modes, token classes and the keyword table for the
// C keyword token classifier.
// ----------------------------------------------------------------------------
package kwtc_pkg;

  localparam int LINE_CHARS = 4096;
  localparam int KW_CHARS   = 8;
  localparam int POS_W      = 12;
  localparam int LEN_W      = 13;
  localparam int CLS_W      = 4;
  localparam int MODE_W     = 3;

  // scanner modes
  localparam logic [MODE_W-1:0] MODE_BETWEEN = 3'd0;
  localparam logic [MODE_W-1:0] MODE_QUOTE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ANGLE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PRE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PLAIN   = 3'd5;

  // token classes
  localparam logic [CLS_W-1:0] CLS_TYPE    = 4'd0;
  localparam logic [CLS_W-1:0] CLS_CONTROL = 4'd1;
  localparam logic [CLS_W-1:0] CLS_RETURN  = 4'd2;
  localparam logic [CLS_W-1:0] CLS_MISC    = 4'd3;
  localparam logic [CLS_W-1:0] CLS_NUMBER  = 4'd4;
  localparam logic [CLS_W-1:0] CLS_STRING  = 4'd5;
  localparam logic [CLS_W-1:0] CLS_COMMENT = 4'd6;
  localparam logic [CLS_W-1:0] CLS_PRE     = 4'd7;
  localparam logic [CLS_W-1:0] CLS_ANGLE   = 4'd8;

  // characters with a meaning to the scanner
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_LT     = 8'd60;
  localparam logic [7:0] CH_GT     = 8'd62;

  typedef logic [KW_CHARS-1:0][7:0] chars_t;

  // text holds the keyword right-aligned, last character in the low byte
  typedef struct packed {
    logic [8*KW_CHARS-1:0] text;
    logic [3:0]            len;
    logic [CLS_W-1:0]      cls;
  } kw_entry_t;

  typedef struct packed {
    logic             hit;
    logic [CLS_W-1:0] cls;
  } cls_res_t;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             last;
  } token_t;

  localparam int KW_COUNT = 24;

  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{64'("int"),      4'd3, CLS_TYPE},
    '{64'("float"),    4'd5, CLS_TYPE},
    '{64'("double"),   4'd6, CLS_TYPE},
    '{64'("char"),     4'd4, CLS_TYPE},
    '{64'("void"),     4'd4, CLS_TYPE},
    '{64'("size_t"),   4'd6, CLS_TYPE},
    '{64'("short"),    4'd5, CLS_TYPE},
    '{64'("long"),     4'd4, CLS_TYPE},
    '{64'("auto"),     4'd4, CLS_TYPE},
    '{64'("if"),       4'd2, CLS_CONTROL},
    '{64'("else"),     4'd4, CLS_CONTROL},
    '{64'("for"),      4'd3, CLS_CONTROL},
    '{64'("while"),    4'd5, CLS_CONTROL},
    '{64'("do"),       4'd2, CLS_CONTROL},
    '{64'("goto"),     4'd4, CLS_CONTROL},
    '{64'("break"),    4'd5, CLS_CONTROL},
    '{64'("continue"), 4'd8, CLS_CONTROL},
    '{64'("switch"),   4'd6, CLS_CONTROL},
    '{64'("case"),     4'd4, CLS_CONTROL},
    '{64'("return"),   4'd6, CLS_RETURN},
    '{64'("const"),    4'd5, CLS_MISC},
    '{64'("typedef"),  4'd7, CLS_MISC},
    '{64'("struct"),   4'd6, CLS_MISC},
    '{64'("NULL"),     4'd4, CLS_MISC}
  };

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_digit(b) || (b >= 8'd65 && b <= 8'd90) ||
           (b >= 8'd97 && b <= 8'd122) || (b == 8'd95);
  endfunction

  function automatic cls_res_t classify(input logic [MODE_W-1:0] mode,
                                        input chars_t           chars,
                                        input logic [LEN_W-1:0] len,
                                        input logic             alld);
    cls_res_t r;
    logic     m;
    r = '{hit: 1'b0, cls: CLS_TYPE};
    case (mode)
      MODE_QUOTE:   r = '{hit: 1'b1, cls: CLS_STRING};
      MODE_ANGLE:   r = '{hit: 1'b1, cls: CLS_ANGLE};
      MODE_COMMENT: r = '{hit: 1'b1, cls: CLS_COMMENT};
      MODE_PRE:     r = '{hit: 1'b1, cls: CLS_PRE};
      MODE_PLAIN: begin
        if (alld && len != '0) begin
          r = '{hit: 1'b1, cls: CLS_NUMBER};
        end else if (len != '0 && len <= LEN_W'(KW_CHARS)) begin
          for (int i = 0; i < KW_COUNT; i++) begin
            m = (len == LEN_W'(KW_TABLE[i].len));
            for (int j = 0; j < KW_CHARS; j++) begin
              if (j < int'(KW_TABLE[i].len)) begin
                if (chars[j] != KW_TABLE[i].text[8*(int'(KW_TABLE[i].len)-1-j) +: 8])
                  m = 1'b0;
              end
            end
            if (m && !r.hit) r = '{hit: 1'b1, cls: KW_TABLE[i].cls};
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/c_keyword_token_classifier.sv =====
`timescale 1ns / 1ps
// A token that a beat closes is queued and offered from the queue head.
// Throughput: one text beat per cycle while text_stall is low; the scanner state
// update and keyword compare finish within the cycle, results go through a
// four-entry queue. A beat that closes two tokens pushes both, to be offered in
// turn; input stalls only while fewer than two queue entries are free.
// Reset (synchronous): scanner returns between words at position 0, queue empties.
// ----------------------------------------------------------------------------
// c_keyword_token_classifier
// Byte-serial lexer for one line of C-like text: splits words, classifies
// strings, angles, comments, preprocessor runs, numbers and keywords.
// ----------------------------------------------------------------------------
module c_keyword_token_classifier
  import kwtc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             text_valid,
  output logic             text_stall,
  input  logic [7:0]       text_byte,
  input  logic             line_end,
  output logic             token_valid,
  input  logic             token_stall,
  output logic [CLS_W-1:0] token_class,
  output logic [POS_W-1:0] token_start,
  output logic [LEN_W-1:0] token_length,
  output logic             run_last
);

  localparam int QD = 4;
  localparam int QA = $clog2(QD);

  // scanner state
  logic [MODE_W-1:0] mode, mode_next;
  logic              quote_dbl, quote_dbl_next;
  logic [POS_W-1:0]  line_pos, line_pos_next;
  logic [POS_W-1:0]  word_start, word_start_next;
  logic [LEN_W-1:0]  word_len, word_len_next;
  logic              all_digits, all_digits_next;
  chars_t            word_chars, word_chars_next;

  // result queue
  token_t            queue [QD];
  logic [QA-1:0]     wptr, rptr;
  logic [QA:0]       count;

  logic              accept, pop;
  logic              consumed, e1_try, e2_try, e1_ok, e2_ok;
  logic [MODE_W-1:0] mode_a, mode_b;
  logic [LEN_W-1:0]  len_app, e1_len;
  chars_t            chars_app;
  cls_res_t          e1, e2;
  token_t            tok1, tok2;
  logic [1:0]        push_n;
  logic [QA-1:0]     widx2;

  assign accept = text_valid && !text_stall;
  assign pop    = token_valid && !token_stall;

  always_comb begin
    len_app = (word_len < LEN_W'(LINE_CHARS)) ? word_len + 1'b1 : word_len;
    for (int i = 0; i < KW_CHARS; i++)
      chars_app[i] = (word_len == LEN_W'(i)) ? text_byte : word_chars[i];

    mode_a   = mode;
    consumed = 1'b0;
    e1_try   = 1'b0;
    e1_len   = word_len;
    unique case (mode)
      MODE_PLAIN: begin
        if (word_len == LEN_W'(1) && word_chars[0] == CH_SLASH && text_byte == CH_SLASH) begin
          mode_a   = MODE_COMMENT;
          consumed = 1'b1;
        end else if (is_word(text_byte)) begin
          consumed = 1'b1;
        end else begin
          e1_try = 1'b1;
          mode_a = MODE_BETWEEN;
        end
      end
      MODE_PRE: begin
        if (text_byte == CH_LT || text_byte == CH_DQUOTE || text_byte == CH_LF) begin
          e1_try = 1'b1;
          mode_a = MODE_BETWEEN;
        end else begin
          consumed = 1'b1;
        end
      end
      MODE_QUOTE: begin
        consumed = 1'b1;
        if (text_byte == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
          e1_try = 1'b1;
          e1_len = len_app;
          mode_a = MODE_BETWEEN;
        end
      end
      MODE_ANGLE: begin
        consumed = 1'b1;
        if (text_byte == CH_GT) begin
          e1_try = 1'b1;
          e1_len = len_app;
          mode_a = MODE_BETWEEN;
        end
      end
      MODE_COMMENT: consumed = 1'b1;
      default:      mode_a = MODE_BETWEEN;
    endcase

    e1    = classify(mode, word_chars, e1_len, all_digits);
    e1_ok = e1_try && e1.hit;

    mode_b          = mode_a;
    quote_dbl_next  = quote_dbl;
    word_start_next = word_start;
    word_len_next   = word_len;
    all_digits_next = all_digits;
    word_chars_next = word_chars;
    if (consumed) begin
      word_len_next   = len_app;
      word_chars_next = chars_app;
      all_digits_next = all_digits && is_digit(text_byte);
    end else if (!is_space(text_byte)) begin
      // new word opens on this beat
      word_start_next    = line_pos;
      word_len_next      = LEN_W'(1);
      all_digits_next    = is_digit(text_byte);
      word_chars_next[0] = text_byte;
      if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE) begin
        mode_b         = MODE_QUOTE;
        quote_dbl_next = (text_byte == CH_DQUOTE);
      end else if (text_byte == CH_LT) begin
        mode_b = MODE_ANGLE;
      end else if (text_byte == CH_HASH) begin
        mode_b = MODE_PRE;
      end else begin
        mode_b = MODE_PLAIN;
      end
    end

    e2_try = line_end && (mode_b != MODE_BETWEEN);
    e2     = classify(mode_b, word_chars_next, word_len_next, all_digits_next);
    e2_ok  = e2_try && e2.hit;

    if (line_end) begin
      mode_next     = MODE_BETWEEN;
      line_pos_next = '0;
    end else begin
      mode_next     = mode_b;
      line_pos_next = (line_pos < POS_W'(LINE_CHARS - 1)) ? line_pos + 1'b1 : line_pos;
    end

    tok1 = '{cls: e1.cls, start: word_start, len: e1_len, last: !e2_ok};
    tok2 = '{cls: e2.cls, start: word_start_next, len: word_len_next, last: 1'b1};
    push_n = accept ? (2'(e1_ok) + 2'(e2_ok)) : 2'd0;
    widx2  = e1_ok ? wptr + 1'b1 : wptr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_BETWEEN;
      quote_dbl  <= 1'b0;
      line_pos   <= '0;
      word_start <= '0;
      word_len   <= '0;
      all_digits <= 1'b1;
    end else if (accept) begin
      mode       <= mode_next;
      quote_dbl  <= quote_dbl_next;
      line_pos   <= line_pos_next;
      word_start <= word_start_next;
      word_len   <= word_len_next;
      all_digits <= all_digits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) word_chars <= word_chars_next;
  end

  always_ff @(posedge clk) begin
    if (accept && e1_ok) queue[wptr]  <= tok1;
    if (accept && e2_ok) queue[widx2] <= tok2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QA'(push_n);
      rptr  <= rptr + QA'(pop);
      count <= count + (QA+1)'(push_n) - (QA+1)'(pop);
    end
  end

  // room for two results per beat
  assign text_stall   = (count > (QA+1)'(QD - 2));
  assign token_valid  = (count != '0);
  assign token_class  = queue[rptr].cls;
  assign token_start  = queue[rptr].start;
  assign token_length = queue[rptr].len;
  assign run_last     = queue[rptr].last;

endmodule

// ===== sim/c_keyword_token_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_keyword_token_classifier_tb
// Feeds lines of C-like text a byte at a time, with random gaps on the text
// side and random stalls on the token side. A scoreboard lexes each accepted
// beat itself and checks every token that comes out, field by field.
// ----------------------------------------------------------------------------
module c_keyword_token_classifier_tb;
  import kwtc_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int RANDOM_BEATS    = 1000;

  class token_scoreboard;
    token_t     pending_tokens[$];
    int         errors;
    int         beats;
    int         lines;
    int         checked;
    int         two_token_beats;
    int         per_class[9];
    logic [MODE_W-1:0] mode;
    bit         dq;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] wstart;
    logic [LEN_W-1:0] wlen;
    logic [7:0] wch[KW_CHARS];
    bit         digits;
    int         made;

    function void clear();
      mode   = MODE_BETWEEN;
      dq     = 1'b0;
      pos    = '0;
      wstart = '0;
      wlen   = '0;
      digits = 1'b1;
      foreach (wch[i]) wch[i] = 8'd0;
    endfunction

    function bit blank_char(logic [7:0] b);
      return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function bit digit_char(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit ident_char(logic [7:0] b);
      return digit_char(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || b == "_";
    endfunction

    function void add_char(logic [7:0] b);
      if (wlen < LEN_W'(KW_CHARS)) wch[wlen] = b;
      if (wlen < LEN_W'(LINE_CHARS)) wlen++;
      if (!digit_char(b)) digits = 1'b0;
    endfunction

    function int keyword_class();
      logic [8*KW_CHARS-1:0] key;
      key = '0;
      for (int i = 0; i < int'(wlen); i++) key = {key[8*KW_CHARS-9:0], wch[i]};
      case (key)
        "int", "float", "double", "char", "void", "size_t", "short", "long",
        "auto": return int'(CLS_TYPE);
        "if", "else", "for", "while", "do", "goto", "break", "continue",
        "switch", "case": return int'(CLS_CONTROL);
        "return": return int'(CLS_RETURN);
        "const", "typedef", "struct", "NULL": return int'(CLS_MISC);
        default: return -1;
      endcase
    endfunction

    function int word_class();
      case (mode)
        MODE_QUOTE:   return int'(CLS_STRING);
        MODE_ANGLE:   return int'(CLS_ANGLE);
        MODE_COMMENT: return int'(CLS_COMMENT);
        MODE_PRE:     return int'(CLS_PRE);
        MODE_PLAIN: begin
          if (digits && wlen != '0) return int'(CLS_NUMBER);
          if (wlen == '0 || wlen > LEN_W'(KW_CHARS)) return -1;
          return keyword_class();
        end
        default: return -1;
      endcase
    endfunction

    function void close_word();
      token_t t;
      int     c;
      c = word_class();
      if (c >= 0 && made < 2) begin
        t.cls   = CLS_W'(c);
        t.start = wstart;
        t.len   = wlen;
        t.last  = 1'b0;
        pending_tokens.push_back(t);
        made++;
      end
      mode = MODE_BETWEEN;
    endfunction

    function void start_word(logic [7:0] b);
      wstart = pos;
      wlen   = '0;
      digits = 1'b1;
      if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        mode = MODE_QUOTE;
        dq   = (b == CH_DQUOTE);
      end else if (b == CH_LT) begin
        mode = MODE_ANGLE;
      end else if (b == CH_HASH) begin
        mode = MODE_PRE;
      end else begin
        mode = MODE_PLAIN;
      end
      add_char(b);
    endfunction

    // lex one accepted beat and queue the tokens it closes
    function void note_beat(logic [7:0] b, logic last);
      bit took;
      took = 1'b0;
      made = 0;
      beats++;
      case (mode)
        MODE_PLAIN: begin
          if (wlen == 1 && wch[0] == CH_SLASH && b == CH_SLASH) begin
            mode = MODE_COMMENT;
            add_char(b);
            took = 1'b1;
          end else if (ident_char(b)) begin
            add_char(b);
            took = 1'b1;
          end else begin
            close_word();
          end
        end
        MODE_PRE: begin
          if (b == CH_LT || b == CH_DQUOTE || b == CH_LF) begin
            close_word();
          end else begin
            add_char(b);
            took = 1'b1;
          end
        end
        MODE_QUOTE: begin
          add_char(b);
          took = 1'b1;
          if (b == (dq ? CH_DQUOTE : CH_SQUOTE)) close_word();
        end
        MODE_ANGLE: begin
          add_char(b);
          took = 1'b1;
          if (b == CH_GT) close_word();
        end
        MODE_COMMENT: begin
          add_char(b);
          took = 1'b1;
        end
        default: mode = MODE_BETWEEN;
      endcase
      if (!took && !blank_char(b)) start_word(b);
      if (last) begin
        if (mode != MODE_BETWEEN) close_word();
        pos = '0;
        lines++;
      end else if (pos < POS_W'(LINE_CHARS - 1)) begin
        pos++;
      end
      if (made > 0) pending_tokens[pending_tokens.size()-1].last = 1'b1;
      if (made == 2) two_token_beats++;
    endfunction

    function void check_token(logic [CLS_W-1:0] cls, logic [POS_W-1:0] start,
                              logic [LEN_W-1:0] len, logic last);
      token_t e;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token class %0d start %0d length %0d last %0b",
                 $time, cls, start, len, last);
        errors++;
        return;
      end
      e = pending_tokens.pop_front();
      checked++;
      if (e.cls <= CLS_ANGLE) per_class[e.cls]++;
      if (cls !== e.cls) begin
        $display("%0t: token_class expected %0d actual %0d", $time, e.cls, cls);
        errors++;
      end
      if (start !== e.start) begin
        $display("%0t: token_start expected %0d actual %0d", $time, e.start, start);
        errors++;
      end
      if (len !== e.len) begin
        $display("%0t: token_length expected %0d actual %0d", $time, e.len, len);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: run_last expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             text_valid = 1'b0;
  logic             text_stall;
  logic [7:0]       text_byte = 8'd0;
  logic             line_end = 1'b0;
  logic             token_valid;
  logic             token_stall = 1'b0;
  logic [CLS_W-1:0] token_class;
  logic [POS_W-1:0] token_start;
  logic [LEN_W-1:0] token_length;
  logic             run_last;

  token_scoreboard sb = new();
  bit         quiet = 1'b0;
  int         sent_beats = 0;
  int         idle_cycles = 0;
  logic [7:0] line_q[$];

  string kw_words[] = '{"int", "float", "double", "char", "void", "size_t", "short",
                        "long", "auto", "if", "else", "for", "while", "do", "goto",
                        "break", "continue", "switch", "case", "return", "const",
                        "typedef", "struct", "NULL", "integer", "Int", "size_tt",
                        "returns", "continues", "_if", "do1", "NUL"};

  c_keyword_token_classifier u_top (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .line_end     (line_end),
    .token_valid  (token_valid),
    .token_stall  (token_stall),
    .token_class  (token_class),
    .token_start  (token_start),
    .token_length (token_length),
    .run_last     (run_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    token_stall <= !quiet && ($urandom_range(0, 99) < 12);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (text_valid && !text_stall) sb.note_beat(text_byte, line_end);
      if (token_valid && !token_stall)
        sb.check_token(token_class, token_start, token_length, run_last);
    end
  end

  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (token_valid && !token_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drive_byte(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      text_valid <= 1'b0;
      @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    line_end   <= last;
    do @(posedge clk); while (text_stall);
    sent_beats++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) drive_byte(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] blank();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 13)) : CH_SPACE;
  endfunction

  function automatic void push_ident(int n);
    string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    line_q.push_back(letters[$urandom_range(0, 52)]);
    for (int i = 1; i < n; i++) line_q.push_back(letters[$urandom_range(0, 62)]);
  endfunction

  // returns 1 when the piece swallows the rest of the line
  function automatic bit push_piece();
    logic [7:0] q;
    int         n;
    string      punct;
    punct = "(){};,=+-*&!";
    n = $urandom_range(0, 6);
    case ($urandom_range(0, 13))
      0, 1, 2: push_str(kw_words[$urandom_range(0, kw_words.size() - 1)]);
      3: push_ident($urandom_range(1, 10));
      4: repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range("0", "9")));
      5, 6: begin
        q = ($urandom_range(0, 1) != 0) ? CH_DQUOTE : CH_SQUOTE;
        line_q.push_back(q);
        repeat (n) line_q.push_back(printable());
        if ($urandom_range(0, 4) != 0) line_q.push_back(q);
      end
      7: begin
        line_q.push_back(CH_LT);
        repeat (n) line_q.push_back(printable());
        if ($urandom_range(0, 4) != 0) line_q.push_back(CH_GT);
      end
      8: begin
        push_str("//");
        repeat (n) line_q.push_back(8'($urandom_range(1, 255)));
        return 1'b1;
      end
      9: begin
        line_q.push_back(CH_HASH);
        push_ident($urandom_range(1, 8));
        case ($urandom_range(0, 3))
          0: line_q.push_back(CH_LT);
          1: line_q.push_back(CH_DQUOTE);
          2: line_q.push_back(CH_LF);
          default: line_q.push_back(CH_SPACE);
        endcase
      end
      10: line_q.push_back(CH_SLASH);
      11: line_q.push_back(punct[$urandom_range(0, punct.len() - 1)]);
      12: line_q.push_back(8'($urandom_range(128, 255)));
      default: begin
        line_q.push_back(8'($urandom_range("0", "9")));
        push_ident($urandom_range(1, 4));
      end
    endcase
    return 1'b0;
  endfunction

  task automatic random_line();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if (push_piece()) break;
        if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 2)) line_q.push_back(blank());
      end
      // an opening quote or angle as the last byte, right after a word, tends to close two tokens at once
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 2))
          0: line_q.push_back(CH_DQUOTE);
          1: line_q.push_back(CH_SQUOTE);
          default: line_q.push_back(CH_LT);
        endcase
      end
    end
    send_line();
  endtask

  initial begin
    int base;
    sb.clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines
    push_str("int\"");
    send_line();
    push_str("#a<");
    send_line();
    push_str("/ 7");
    send_line();
    push_str("//c");
    send_line();
    line_q.push_back(8'hFF);
    push_str("9");
    send_line();
    push_str("'a\"'");
    send_line();
    push_str("<x");
    send_line();

    base = sent_beats;
    while (sent_beats < base + RANDOM_BEATS) begin
      quiet = (sent_beats >= base + 400) && (sent_beats < base + 600);
      random_line();
    end
    quiet = 1'b0;

    for (int i = 0; i < 5; i++) random_line();

    text_valid <= 1'b0;
    while (sb.pending_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Lexed %0d beats over %0d lines, checked %0d tokens, %0d beats closed two tokens",
             sb.beats, sb.lines, sb.checked, sb.two_token_beats);
    $display("Tokens by class: type %0d control %0d return %0d misc %0d number %0d",
             sb.per_class[0], sb.per_class[1], sb.per_class[2], sb.per_class[3],
             sb.per_class[4]);
    if (sb.errors == 0 && sb.pending_tokens.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/kwtc_pkg.sv
rtl/core/c_keyword_token_classifier.sv
sim/c_keyword_token_classifier_tb.sv
